@@ hdl/mcpg_pkg.sv @@
`timescale 1ns / 1ps

package mcpg_pkg;

    localparam int CENTER_W = 15;
    localparam int RADIUS_W = 14;
    localparam int COLOR_W  = 32;
    localparam int OUT_W    = 16;
    localparam int DEC_W    = 17;
    localparam int IDX_W    = 3;
    localparam int SUM_W    = 17;

    localparam logic [IDX_W-1:0] IDX_AXIS_LAST  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_OCTANT_LAST = 3'd7;

    typedef enum logic {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        operation;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [RADIUS_W-1:0]        radius;
        logic [COLOR_W-1:0]         point_color;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic [COLOR_W-1:0]      point_rgba;
        logic                    last;
    } t_point;

    typedef struct packed {
        logic active;
        logic x_le_y;
    } t_step_status;

endpackage

@@ hdl/mcpg_in_stage.sv @@
`timescale 1ns / 1ps

module mcpg_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mcpg_pkg::t_item i_item,
    input  logic            i_down_free,
    output logic            o_valid,
    output logic            o_fire,
    output mcpg_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    mcpg_pkg::t_item r_item;

    assign o_fire  = r_valid && i_down_free;
    assign o_ready = !r_valid || i_down_free;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (o_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hdl/mcpg_step.sv @@
`timescale 1ns / 1ps

module mcpg_step #(
    parameter int COORD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  mcpg_pkg::t_item        i_item,
    output logic                   o_emit,
    output mcpg_pkg::t_point       o_point,
    output mcpg_pkg::t_step_status o_status
);

    localparam int WRAP_W = (COORD_BITS < mcpg_pkg::OUT_W) ? COORD_BITS : mcpg_pkg::OUT_W;

    logic                                 r_active;
    logic signed [mcpg_pkg::CENTER_W-1:0] r_cx;
    logic signed [mcpg_pkg::CENTER_W-1:0] r_cy;
    logic [mcpg_pkg::COLOR_W-1:0]         r_color;
    logic [mcpg_pkg::RADIUS_W-1:0]        r_sx;
    logic [mcpg_pkg::RADIUS_W-1:0]        r_sy;
    logic signed [mcpg_pkg::DEC_W-1:0]    r_dec;
    logic [mcpg_pkg::IDX_W-1:0]           r_k;

    logic                                 n_active;
    logic signed [mcpg_pkg::CENTER_W-1:0] n_cx;
    logic signed [mcpg_pkg::CENTER_W-1:0] n_cy;
    logic [mcpg_pkg::COLOR_W-1:0]         n_color;
    logic [mcpg_pkg::RADIUS_W-1:0]        n_sx;
    logic [mcpg_pkg::RADIUS_W-1:0]        n_sy;
    logic signed [mcpg_pkg::DEC_W-1:0]    n_dec;
    logic [mcpg_pkg::IDX_W-1:0]           n_k;

    logic                                 w_start;
    logic signed [mcpg_pkg::CENTER_W-1:0] w_cx;
    logic signed [mcpg_pkg::CENTER_W-1:0] w_cy;
    logic [mcpg_pkg::RADIUS_W-1:0]        w_x;
    logic [mcpg_pkg::RADIUS_W-1:0]        w_y;
    logic [mcpg_pkg::IDX_W-1:0]           w_k;
    logic signed [mcpg_pkg::CENTER_W-1:0] w_dx;
    logic signed [mcpg_pkg::CENTER_W-1:0] w_dy;
    logic signed [mcpg_pkg::SUM_W-1:0]    w_sum_x;
    logic signed [mcpg_pkg::SUM_W-1:0]    w_sum_y;
    logic signed [WRAP_W-1:0]             w_wrap_x;
    logic signed [WRAP_W-1:0]             w_wrap_y;
    logic                                 w_last;

    logic                                 w_four;
    logic                                 w_step_end;
    logic [mcpg_pkg::RADIUS_W-1:0]        w_x1;
    logic [mcpg_pkg::RADIUS_W-1:0]        w_y1;
    logic signed [mcpg_pkg::OUT_W-1:0]    w_diff;
    logic signed [mcpg_pkg::DEC_W:0]      w_dec_sum;

    assign w_start = (i_item.operation == mcpg_pkg::OP_START);
    assign w_cx    = w_start ? i_item.center_x : r_cx;
    assign w_cy    = w_start ? i_item.center_y : r_cy;
    assign w_x     = w_start ? '0 : r_sx;
    assign w_y     = w_start ? i_item.radius : r_sy;
    assign w_k     = w_start ? '0 : r_k;

    always_comb begin
        logic signed [mcpg_pkg::CENTER_W-1:0] v_a;
        logic signed [mcpg_pkg::CENTER_W-1:0] v_b;
        logic signed [mcpg_pkg::CENTER_W-1:0] v_y;
        v_y = $signed({1'b0, w_y});
        v_a = w_k[2] ? $signed({1'b0, w_y}) : $signed({1'b0, w_x});
        v_b = w_k[2] ? $signed({1'b0, w_x}) : $signed({1'b0, w_y});
        if (w_x == '0) begin
            w_dx = w_k[1] ? (w_k[0] ? -v_y : v_y) : '0;
            w_dy = w_k[1] ? '0 : (w_k[0] ? -v_y : v_y);
        end else begin
            w_dx = w_k[0] ? -v_a : v_a;
            w_dy = w_k[1] ? -v_b : v_b;
        end
    end

    assign w_sum_x  = mcpg_pkg::SUM_W'(w_cx) + mcpg_pkg::SUM_W'(w_dx);
    assign w_sum_y  = mcpg_pkg::SUM_W'(w_cy) + mcpg_pkg::SUM_W'(w_dy);
    assign w_wrap_x = w_sum_x[WRAP_W-1:0];
    assign w_wrap_y = w_sum_y[WRAP_W-1:0];

    assign w_four     = (r_sx == '0) || (r_sx == r_sy);
    assign w_step_end = w_four ? (r_k == mcpg_pkg::IDX_AXIS_LAST)
                               : (r_k == mcpg_pkg::IDX_OCTANT_LAST);
    assign w_x1       = r_sx + 1'b1;
    assign w_y1       = r_dec[mcpg_pkg::DEC_W-1] ? r_sy : r_sy - 1'b1;
    assign w_diff     = $signed({2'b00, w_x1}) - $signed({2'b00, w_y1});
    assign w_dec_sum  = r_dec[mcpg_pkg::DEC_W-1]
                      ? ((mcpg_pkg::DEC_W+1)'(r_dec)
                         + (mcpg_pkg::DEC_W+1)'($signed({2'b00, w_x1, 1'b1})))
                      : ((mcpg_pkg::DEC_W+1)'(r_dec)
                         + (mcpg_pkg::DEC_W+1)'($signed({w_diff, 1'b1})));

    always_comb begin
        n_active = r_active;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_color  = r_color;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_dec    = r_dec;
        n_k      = r_k;
        w_last   = 1'b0;
        if (w_start) begin
            n_active = 1'b1;
            n_cx     = i_item.center_x;
            n_cy     = i_item.center_y;
            n_color  = i_item.point_color;
            n_sx     = '0;
            n_sy     = i_item.radius;
            n_dec    = $signed(mcpg_pkg::DEC_W'(1) - {3'b000, i_item.radius});
            n_k      = mcpg_pkg::IDX_W'(1);
        end else if (r_active) begin
            if (!w_step_end) begin
                n_k = r_k + 1'b1;
            end else if (r_sx < r_sy) begin
                n_sx  = w_x1;
                n_sy  = w_y1;
                n_dec = w_dec_sum[mcpg_pkg::DEC_W-1:0];
                n_k   = '0;
                if (w_x1 > w_y1) begin
                    n_active = 1'b0;
                    w_last   = 1'b1;
                end
            end else begin
                n_active = 1'b0;
                w_last   = 1'b1;
            end
        end
    end

    assign o_emit             = w_start || r_active;
    assign o_point.point_x    = mcpg_pkg::OUT_W'(w_wrap_x);
    assign o_point.point_y    = mcpg_pkg::OUT_W'(w_wrap_y);
    assign o_point.point_rgba = w_start ? i_item.point_color : r_color;
    assign o_point.last       = w_last;
    assign o_status.active    = r_active;
    assign o_status.x_le_y    = (r_sx <= r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_k      <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
        end else if (i_fire) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_color <= '0;
            r_dec   <= '0;
        end else if (i_fire) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_color <= n_color;
            r_dec   <= n_dec;
        end
    end

endmodule

@@ hdl/mcpg_out_stage.sv @@
`timescale 1ns / 1ps

module mcpg_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mcpg_pkg::t_point i_point,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output mcpg_pkg::t_point o_point
);

    logic             r_valid;
    logic             n_valid;
    mcpg_pkg::t_point r_point;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_point = r_point;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_point <= i_point;
        end
    end

endmodule

@@ hdl/midpoint_circle_point_generator_core.sv @@
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)                                   | tuser     | tlast
// s_axis  | in  | center_x 15, center_y 15, radius 14, point_color 32, pad 4 | operation | -
// m_axis  | out | point_x 16, point_y 16, point_rgba 32                | -         | last
//
// One beat in, at most one beat out; a beat is taken every cycle when the output is free.
// The path runs through the input register, then the step logic into the output register.
// A next beat while no circle is active produces nothing.
// A stalled output holds the output register and backs up into the input register.
// i_rst_n is synchronous, active low, and drops any circle in progress.

module midpoint_circle_point_generator_core #(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // center_x, center_y, radius, point_color, zero pad
    input  logic [0:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // point_x, point_y, point_rgba
    output logic        m_axis_tlast
);

    mcpg_pkg::t_item        w_in_item;
    mcpg_pkg::t_item        w_item;
    mcpg_pkg::t_point       w_point;
    mcpg_pkg::t_point       w_out_point;
    mcpg_pkg::t_step_status w_status;
    logic                   w_in_valid;
    logic                   w_fire;
    logic                   w_emit;
    logic                   w_out_free;

    assign w_in_item.operation   = mcpg_pkg::t_op'(s_axis_tuser[0]);
    assign w_in_item.center_x    = s_axis_tdata[14:0];
    assign w_in_item.center_y    = s_axis_tdata[29:15];
    assign w_in_item.radius      = s_axis_tdata[43:30];
    assign w_in_item.point_color = s_axis_tdata[75:44];

    mcpg_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (w_in_item),
        .i_down_free (w_out_free),
        .o_valid     (w_in_valid),
        .o_fire      (w_fire),
        .o_item      (w_item)
    );

    mcpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_emit   (w_emit),
        .o_point  (w_point),
        .o_status (w_status)
    );

    mcpg_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_emit),
        .i_point (w_point),
        .i_ready (m_axis_tready),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .o_point (w_out_point)
    );

    assign m_axis_tdata = {w_out_point.point_rgba, w_out_point.point_y, w_out_point.point_x};
    assign m_axis_tlast = w_out_point.last;

    a_walk_in_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.active |-> w_status.x_le_y)
        else $error("active circle walk left the octant");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_out_free) |=> (w_in_valid && $stable(w_item)))
        else $error("input register lost a beat while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_valid |-> s_axis_tready)
        else $error("empty input register refused a beat");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_fire && w_emit))
        else $error("output beat appeared without a step");

endmodule
